// ===== rtl/first_fit_heap_allocator_core_assert.svh =====
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// condition in the same cycle
`define FFHA_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ffha assertion failed");

// condition in the next cycle
`define FFHA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ffha assertion failed");

`endif

// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int CELLS        = MAX_SEGMENTS - 1;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int SEG_W        = 17;
    localparam int BLOCK_SHIFT  = 6;
    localparam int HEADER_BYTES = 40;
    localparam int HEAP_BLOCKS  = 65536;
    localparam int NEED_W       = 33 - BLOCK_SHIFT;

    localparam logic       KIND_ALLOC = 1'b0;
    localparam logic       KIND_FREE  = 1'b1;

    localparam logic       CFG_HEAP_START = 1'b0;
    localparam logic       CFG_HEAP_END   = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FIT   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NULL     = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd4;
    localparam logic [2:0] ST_OUTSIDE  = 3'd5;

    typedef struct packed {
        logic [SEG_W-1:0] start;
        logic [SEG_W-1:0] length;
        logic             taken;
    } seg_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] size_bytes;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_address;
        logic [16:0] granted_blocks;
    } rsp_t;

endpackage

// ===== rtl/ffha_req_if.sv =====
interface ffha_req_if;
    import ffha_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/ffha_rsp_if.sv =====
interface ffha_rsp_if;
    import ffha_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/ffha_cell.sv =====
module ffha_cell (
    input  logic          clk,
    input  logic          shift_en,
    input  logic          load_en,
    input  ffha_pkg::seg_t load_data,
    input  ffha_pkg::seg_t shift_in,
    output ffha_pkg::seg_t q
);
    import ffha_pkg::*;

    seg_t seg_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            seg_reg <= load_data;
        end
        else if (shift_en)
        begin
            seg_reg <= shift_in;
        end
    end

    assign q = seg_reg;
endmodule

// ===== rtl/first_fit_heap_allocator_core.sv =====
// sequence: a request that changes the table runs search, decide, update and result;
//   a request that fails after the search skips the update, and a free rejected on its
//   pointer alone goes straight to the result
// throughput: one word at a time; the next word is accepted in the cycle after the result
//   is registered, which waits while the previous response is not taken
// reset: table holds one free segment over the heap (none if it is empty), built in the
//   cycle after reset or after any register write, during which no word is accepted
module first_fit_heap_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    ffha_req_if.sink    req,
    ffha_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import ffha_pkg::*;
    `include "first_fit_heap_allocator_core_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_SEGMENTS - 1);

    logic [31:0]       heap_start_reg, heap_end_reg;
    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    seg_t              h_reg, h_next;
    seg_t              x_reg, x_next;
    logic              xv_reg, xv_next;
    req_t              cur_reg, cur_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [SEG_W-1:0]  blk_reg, blk_next;
    logic              found_reg, found_next;
    logic              hit_taken_reg, hit_taken_next;
    logic [IDX_W-1:0]  t_reg, t_next;
    logic [SEG_W-1:0]  fstart_reg, fstart_next;
    logic [SEG_W-1:0]  lt_reg, lt_next;
    logic [SEG_W-1:0]  lp_reg, lp_next;
    logic [SEG_W-1:0]  ln_reg, ln_next;
    logic              mp_reg, mp_next;
    logic              nf_reg, nf_next;
    logic              split_reg, split_next;
    seg_t              prev_reg, prev_next;
    rsp_t              res_reg, res_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    seg_t              cell_q [CELLS];
    seg_t              e0, e1, e2;
    seg_t              init_seg;
    logic              shift_en;

    logic [31:0]       diff;
    logic [SEG_W-1:0]  hb;
    logic [32:0]       need_sum;
    logic [NEED_W-1:0] need_w;
    logic [32:0]       addr33, lo33, off33;
    logic              in_range;
    logic [SEG_W-1:0]  tail_len;
    seg_t              special;

    // heap size in blocks
    always_comb
    begin
        diff = heap_end_reg - heap_start_reg;
        if (heap_end_reg <= heap_start_reg)
        begin
            hb = '0;
        end
        else if (diff[31:BLOCK_SHIFT+16] != '0)
        begin
            hb = SEG_W'(HEAP_BLOCKS);
        end
        else
        begin
            hb = {1'b0, diff[BLOCK_SHIFT+15:BLOCK_SHIFT]};
        end
    end

    assign init_seg = '{start: '0, length: hb, taken: 1'b0};
    assign shift_en = (state_reg == S_SCAN) || (state_reg == S_MOD);

    // ring of segment cells, the controller register closes the loop
    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                ffha_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .load_en  (1'b0),
                    .load_data(init_seg),
                    .shift_in (h_reg),
                    .q        (cell_q[gi])
                );
            end
            else if (gi == CELLS - 1)
            begin : g_tail
                ffha_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .load_en  (state_reg == S_INIT),
                    .load_data(init_seg),
                    .shift_in (cell_q[gi-1]),
                    .q        (cell_q[gi])
                );
            end
            else
            begin : g_mid
                ffha_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .load_en  (1'b0),
                    .load_data(init_seg),
                    .shift_in (cell_q[gi-1]),
                    .q        (cell_q[gi])
                );
            end
        end
    endgenerate

    assign e0 = cell_q[CELLS-1];
    assign e1 = cell_q[CELLS-2];
    assign e2 = cell_q[CELLS-3];

    assign need_sum = {1'b0, req.payload.size_bytes} + 33'(HEADER_BYTES)
                      + 33'((1 << BLOCK_SHIFT) - 1);
    assign need_w   = (need_sum[32:BLOCK_SHIFT] == '0) ? NEED_W'(1)
                                                       : need_sum[32:BLOCK_SHIFT];
    assign addr33   = {1'b0, req.payload.address};
    assign lo33     = {1'b0, heap_start_reg} + 33'(HEADER_BYTES);
    assign off33    = addr33 - lo33;
    assign in_range = {1'b0, step_reg} < count_reg;
    assign tail_len = nf_reg ? ln_reg : '0;

    always_comb
    begin
        special.start  = e0.start;
        special.length = mp_reg ? (lp_reg + lt_reg + tail_len) : (lt_reg + tail_len);
        special.taken  = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        h_next         = h_reg;
        x_next         = x_reg;
        xv_next        = xv_reg;
        cur_next       = cur_reg;
        need_next      = need_reg;
        blk_next       = blk_reg;
        found_next     = found_reg;
        hit_taken_next = hit_taken_reg;
        t_next         = t_reg;
        fstart_next    = fstart_reg;
        lt_next        = lt_reg;
        lp_next        = lp_reg;
        ln_next        = ln_reg;
        mp_next        = mp_reg;
        nf_next        = nf_reg;
        split_next     = split_reg;
        prev_next      = prev_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cur_next   = req.payload;
                    need_next  = need_w;
                    blk_next   = off33[BLOCK_SHIFT+SEG_W-1:BLOCK_SHIFT];
                    step_next  = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                    res_next   = '0;
                    if (req.payload.kind == KIND_FREE)
                    begin
                        priority if (req.payload.address == '0)
                        begin
                            res_next.status = ST_NULL;
                            state_next      = S_FIN;
                        end
                        else if (addr33 < lo33)
                        begin
                            res_next.status = ST_OUTSIDE;
                            state_next      = S_FIN;
                        end
                        else if (off33 >= 33'({hb, BLOCK_SHIFT'(0)}))
                        begin
                            res_next.status = ST_OUTSIDE;
                            state_next      = S_FIN;
                        end
                        else if (off33[BLOCK_SHIFT-1:0] != '0)
                        begin
                            res_next.status = ST_NOT_ALLOC;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_INIT:
            begin
                count_next = (hb != '0) ? CNT_W'(1) : '0;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                h_next    = e0;
                prev_next = e0;
                if (!found_reg && in_range)
                begin
                    if (cur_reg.kind == KIND_ALLOC)
                    begin
                        if (!e0.taken && (NEED_W'(e0.length) >= need_reg))
                        begin
                            found_next  = 1'b1;
                            t_next      = step_reg;
                            fstart_next = e0.start;
                            lt_next     = e0.length;
                        end
                    end
                    else if (e0.start == blk_reg)
                    begin
                        found_next     = 1'b1;
                        t_next         = step_reg;
                        hit_taken_next = e0.taken;
                        lt_next        = e0.length;
                        lp_next        = prev_reg.length;
                        mp_next        = (step_reg != '0) && !prev_reg.taken;
                        ln_next        = e1.length;
                        nf_next        = (({1'b0, step_reg} + CNT_W'(1)) < count_reg)
                                         && !e1.taken;
                    end
                end
                step_next = step_reg + IDX_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_next   = '0;
                xv_next    = 1'b0;
                split_next = NEED_W'(lt_reg) > need_reg;
                if (cur_reg.kind == KIND_ALLOC)
                begin
                    if (!found_reg)
                    begin
                        res_next.status = ST_NO_FIT;
                        state_next      = S_FIN;
                    end
                    else if ((NEED_W'(lt_reg) > need_reg)
                             && (count_reg == CNT_W'(MAX_SEGMENTS)))
                    begin
                        res_next.status = ST_FULL;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        res_next.status          = ST_OK;
                        res_next.granted_address = heap_start_reg
                            + 32'({fstart_reg, BLOCK_SHIFT'(0)}) + 32'(HEADER_BYTES);
                        res_next.granted_blocks  = 17'(need_reg);
                        state_next               = S_MOD;
                    end
                end
                else
                begin
                    if (!found_reg || !hit_taken_reg)
                    begin
                        res_next.status = ST_NOT_ALLOC;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        res_next.status         = ST_OK;
                        res_next.granted_blocks = lt_reg;
                        state_next              = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (cur_reg.kind == KIND_ALLOC)
                begin
                    if (step_reg == t_reg)
                    begin
                        h_next = '{start: e0.start, length: SEG_W'(need_reg), taken: 1'b1};
                        if (split_reg)
                        begin
                            x_next  = '{start: e0.start + SEG_W'(need_reg),
                                        length: e0.length - SEG_W'(need_reg),
                                        taken: 1'b0};
                            xv_next = 1'b1;
                        end
                    end
                    else if (xv_reg)
                    begin
                        h_next = x_reg;
                        x_next = e0;
                    end
                    else
                    begin
                        h_next = e0;
                    end
                end
                else
                begin
                    if (mp_reg)
                    begin
                        priority if (step_reg == t_reg - IDX_W'(1))
                        begin
                            h_next = special;
                        end
                        else if (step_reg >= t_reg)
                        begin
                            h_next = nf_reg ? e2 : e1;
                        end
                        else
                        begin
                            h_next = e0;
                        end
                    end
                    else
                    begin
                        priority if (step_reg == t_reg)
                        begin
                            h_next = special;
                        end
                        else if (step_reg > t_reg)
                        begin
                            h_next = nf_reg ? e1 : e0;
                        end
                        else
                        begin
                            h_next = e0;
                        end
                    end
                end
                step_next = step_reg + IDX_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    if (cur_reg.kind == KIND_ALLOC)
                    begin
                        count_next = count_reg + CNT_W'(split_reg);
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(mp_reg) - CNT_W'(nf_reg);
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_we)
        begin
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= '0;
            heap_end_reg   <= 32'd4194304;
            state_reg      <= S_INIT;
            step_reg       <= '0;
            count_reg      <= '0;
            xv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HEAP_START: heap_start_reg <= cfg_data;
                    CFG_HEAP_END:   heap_end_reg   <= cfg_data;
                    default:        heap_end_reg   <= heap_end_reg;
                endcase
            end
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            xv_reg        <= xv_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg         <= h_next;
        x_reg         <= x_next;
        cur_reg       <= cur_next;
        need_reg      <= need_next;
        blk_reg       <= blk_next;
        hit_taken_reg <= hit_taken_next;
        t_reg         <= t_next;
        fstart_reg    <= fstart_next;
        lt_reg        <= lt_next;
        lp_reg        <= lp_next;
        ln_reg        <= ln_next;
        mp_reg        <= mp_next;
        nf_reg        <= nf_next;
        split_reg     <= split_next;
        prev_reg      <= prev_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    assign req.ready   = (state_reg == S_IDLE) && !cfg_we;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    `FFHA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_SEGMENTS))
    `FFHA_ASSERT_IMP(a_scan_wrap, clk, rst_n, (state_reg == S_DEC),
                     step_reg == '0)
    `FFHA_ASSERT_NEXT(a_full_no_split, clk, rst_n,
                      (state_reg == S_MOD) && (count_reg == CNT_W'(MAX_SEGMENTS)),
                      !xv_reg)
endmodule
